// ===== rtl/fm_synth_voice_engine_defines.svh =====
// Assertion macros for the FM voice engine.
// Used by the top level only; expects aclk and aresetn in scope.
`ifndef FM_SYNTH_VOICE_ENGINE_DEFINES_SVH
`define FM_SYNTH_VOICE_ENGINE_DEFINES_SVH

// same-cycle implication
`define FMSV_ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("fm_synth_voice_engine: implication check failed");

// next-cycle implication
`define FMSV_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("fm_synth_voice_engine: next-cycle check failed");

`endif

// ===== rtl/fmsv_pkg.sv =====
// Shared types and constants of the FM voice engine.
// No dependencies; used by fmsv_mul and fm_synth_voice_engine.
package fmsv_pkg;

    // digit-serial multiplier geometry
    localparam int MUL_A_W   = 36;
    localparam int MUL_B_W   = 32;
    localparam int MUL_P_W   = MUL_A_W + MUL_B_W;
    localparam int DIGIT_W   = 8;
    localparam int MUL_STEPS = MUL_B_W / DIGIT_W;

    // envelope stage codes
    typedef enum logic [1:0] {
        STG_RELEASE = 2'd0,
        STG_ATTACK  = 2'd1,
        STG_DECAY   = 2'd2,
        STG_HOLD    = 2'd3
    } stage_t;

    // one operator entry of the operator store
    typedef struct packed {
        logic [31:0] phase;
        logic [24:0] level;
        stage_t      stage;
    } op_word_t;

    // input kinds
    localparam logic [1:0] MODE_TICK = 2'd0;
    localparam logic [1:0] MODE_ON   = 2'd1;
    localparam logic [1:0] MODE_OFF  = 2'd2;

    // configuration register indexes
    localparam logic [3:0] CFG_ATTACK_A  = 4'd0;
    localparam logic [3:0] CFG_ATTACK_B  = 4'd1;
    localparam logic [3:0] CFG_DECAY_A   = 4'd2;
    localparam logic [3:0] CFG_DECAY_B   = 4'd3;
    localparam logic [3:0] CFG_RELEASE_A = 4'd4;
    localparam logic [3:0] CFG_RELEASE_B = 4'd5;
    localparam logic [3:0] CFG_TUNING_B  = 4'd6;
    localparam logic [3:0] CFG_VOLUME_B  = 4'd7;

    // configuration reset values
    localparam logic [24:0] RST_ATTACK_A  = 25'd335544;
    localparam logic [24:0] RST_ATTACK_B  = 25'd8389;
    localparam logic [31:0] RST_DECAY_A   = 32'd4294954411;
    localparam logic [31:0] RST_DECAY_B   = 32'd4294924346;
    localparam logic [31:0] RST_RELEASE_A = 32'd4291960819;
    localparam logic [31:0] RST_RELEASE_B = 32'd4294537799;
    localparam logic [19:0] RST_TUNING_B  = 20'd66191;
    localparam logic [16:0] RST_VOLUME_B  = 17'd39322;

    // fixed values
    localparam logic [25:0] ONE_Q24        = 26'd16777216;
    localparam logic [24:0] SUSTAIN_A      = 25'd8388608;
    localparam logic [24:0] SUSTAIN_B      = 25'd11744051;
    localparam logic [16:0] VOL_A          = 17'd65536;
    localparam logic [31:0] MIX_SCALE      = 32'd3000;
    localparam logic [31:0] OFFSET_EIGHTH  = 32'h2000_0000;
    localparam logic [31:0] OFFSET_QUARTER = 32'h4000_0000;
    localparam logic [6:0]  NOTE_LIMIT     = 7'd95;

    // top octave phase increments, one per semitone
    function automatic logic [31:0] top_octave(input logic [3:0] k);
        logic [31:0] v;
        case (k)
            4'd0:    v = 32'd101920476;
            4'd1:    v = 32'd107980983;
            4'd2:    v = 32'd114401866;
            4'd3:    v = 32'd121204555;
            4'd4:    v = 32'd128411753;
            4'd5:    v = 32'd136047513;
            4'd6:    v = 32'd144137319;
            4'd7:    v = 32'd152708170;
            4'd8:    v = 32'd161788699;
            4'd9:    v = 32'd171409126;
            4'd10:   v = 32'd181601643;
            4'd11:   v = 32'd192400238;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

endpackage

// ===== rtl/fmsv_mul.sv =====
// Digit-serial unsigned multiplier, one 8-bit digit of b per cycle.
// Depends on fmsv_pkg for operand widths.
module fmsv_mul (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [fmsv_pkg::MUL_A_W-1:0]  a,
    input  logic [fmsv_pkg::MUL_B_W-1:0]  b,
    output logic                          busy,
    output logic                          done,
    output logic [fmsv_pkg::MUL_P_W-1:0]  prod
);

    localparam int CW = $clog2(fmsv_pkg::MUL_STEPS);
    localparam int TW = fmsv_pkg::MUL_A_W + fmsv_pkg::DIGIT_W;

    logic [fmsv_pkg::MUL_A_W-1:0] a_reg;
    logic [fmsv_pkg::MUL_B_W-1:0] b_reg;
    logic [fmsv_pkg::MUL_P_W-1:0] prod_reg;
    logic [CW-1:0]                cnt_reg;
    logic                         busy_reg;
    logic                         done_reg;
    logic [TW-1:0]                step_sum;

    // partial product of one digit added to the upper half
    assign step_sum = TW'(prod_reg[fmsv_pkg::MUL_P_W-1:fmsv_pkg::MUL_B_W])
                    + TW'(a_reg) * TW'(b_reg[fmsv_pkg::DIGIT_W-1:0]);

    // control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CW'(fmsv_pkg::MUL_STEPS - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // operand and product shift registers
    always_ff @(posedge aclk) begin
        if (start) begin
            a_reg    <= a;
            b_reg    <= b;
            prod_reg <= '0;
        end else if (busy_reg) begin
            b_reg    <= b_reg >> fmsv_pkg::DIGIT_W;
            prod_reg <= {step_sum,
                         prod_reg[fmsv_pkg::MUL_B_W-1:fmsv_pkg::DIGIT_W]};
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign prod = prod_reg;

endmodule

// ===== rtl/fm_synth_voice_engine.sv =====
// FM voice engine: VOICES voices of three operators, stereo output per tick.
// Tick: paced by the shared digit-serial multiplier, each multiply running through
// issue, 4 digits and done; up to 22 multiplies per voice.
// Note-on: activity scan, one operator read per SCAN_RD/SCAN pair, then the chosen voice restarts.
// Note-off: releases each voice holding the note. One item at a time; a finished sample
// waits in the output register while the next item is taken. Sync active-low reset.
`include "fm_synth_voice_engine_defines.svh"
module fm_synth_voice_engine #(
    parameter int VOICES       = 8,
    parameter int SINE_ENTRIES = 1024
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [6:0] note, [7] zero
    input  logic [1:0]  s_tuser,   // [1:0] mode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [15:0] left_sample, [31:16] right_sample
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [3:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    localparam int OPS   = 3 * VOICES;
    localparam int AW    = $clog2(OPS);
    localparam int VW    = (VOICES > 1) ? $clog2(VOICES) : 1;
    localparam int IW    = $clog2(SINE_ENTRIES);
    localparam int SUM_W = 38;
    localparam int PW    = fmsv_pkg::MUL_P_W;

    localparam longint unsigned PI_Q30      = 64'd3373259426;
    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
    localparam longint unsigned TWO_PI_Q30  = 64'd6746518852;

    typedef logic signed [31:0] rom_t [SINE_ENTRIES];

    typedef enum logic [19:0] {
        ST_IDLE     = 20'h00001,
        ST_SCAN_RD  = 20'h00002,
        ST_SCAN     = 20'h00004,
        ST_ON_RD    = 20'h00008,
        ST_ON_WR    = 20'h00010,
        ST_OFF_CHK  = 20'h00020,
        ST_OFF_RD   = 20'h00040,
        ST_OFF_WR   = 20'h00080,
        ST_INCB     = 20'h00100,
        ST_RD       = 20'h00200,
        ST_ENV      = 20'h00400,
        ST_ENV_WR   = 20'h00800,
        ST_AMP_IDX  = 20'h01000,
        ST_AMP_ROM  = 20'h02000,
        ST_AMP_M2   = 20'h04000,
        ST_AMP_END  = 20'h08000,
        ST_MIX      = 20'h10000,
        ST_MIX_END  = 20'h20000,
        ST_OUT      = 20'h40000,
        ST_MWAIT    = 20'h80000
    } state_t;

    // sine table entry: Taylor series on the folded quarter wave
    function automatic logic signed [31:0] sine_entry(input int unsigned i);
        longint unsigned th;
        longint unsigned x2;
        longint unsigned term;
        longint          sum;
        logic            neg;
        th  = (TWO_PI_Q30 * longint'(i)) / SINE_ENTRIES;
        neg = 1'b0;
        if (th >= PI_Q30) begin
            th  = th - PI_Q30;
            neg = 1'b1;
        end
        if (th > HALF_PI_Q30) begin
            th = (th <= PI_Q30) ? PI_Q30 - th : 64'd0;
        end
        x2   = (th * th) >> 30;
        term = th;
        sum  = longint'(th);
        term = ((term * x2) >> 30) / 6;   sum = sum - longint'(term);
        term = ((term * x2) >> 30) / 20;  sum = sum + longint'(term);
        term = ((term * x2) >> 30) / 42;  sum = sum - longint'(term);
        term = ((term * x2) >> 30) / 72;  sum = sum + longint'(term);
        term = ((term * x2) >> 30) / 110; sum = sum - longint'(term);
        term = ((term * x2) >> 30) / 156; sum = sum + longint'(term);
        term = ((term * x2) >> 30) / 210; sum = sum - longint'(term);
        if (sum < 0) sum = 0;
        if (sum > 64'sd1073741824) sum = 64'sd1073741824;
        return neg ? 32'(-sum) : 32'(sum);
    endfunction

    function automatic rom_t build_rom();
        rom_t r;
        for (int i = 0; i < SINE_ENTRIES; i++) begin
            r[i] = sine_entry(i);
        end
        return r;
    endfunction

    localparam rom_t SINE_ROM = build_rom();

    // note number to phase increment: octave by compare, semitone from table
    function automatic logic [31:0] note_increment(input logic [6:0] n);
        logic [2:0]  oct;
        logic [6:0]  rem;
        logic [2:0]  sh;
        logic [31:0] base;
        oct = 3'd0;
        rem = n;
        for (int k = 1; k < 8; k++) begin
            if (n >= 7'(12 * k)) begin
                oct = 3'(k);
                rem = n - 7'(12 * k);
            end
        end
        sh   = 3'd7 - oct;
        base = fmsv_pkg::top_octave(rem[3:0]);
        return (base + ((32'd1 << sh) >> 1)) >> sh;
    endfunction

    // configuration
    logic [24:0] attack_a_reg, attack_b_reg;
    logic [31:0] decay_a_reg, decay_b_reg, release_a_reg, release_b_reg;
    logic [19:0] tuning_b_reg;
    logic [16:0] volume_b_reg;

    // control
    state_t            state_reg, state_next, ret_reg;
    logic [VW-1:0]     voice_reg, best_v_reg;
    logic [1:0]        opj_reg;
    logic [2:0]        amp_k_reg;
    logic              side_reg;
    logic              m_tvalid_reg;
    logic [OPS-1:0]    op_vld_reg;
    logic [6:0]        voice_note_reg [VOICES];
    logic [31:0]       voice_inc_reg  [VOICES];

    // datapath
    logic [6:0]               note_reg;
    fmsv_pkg::op_word_t       op_mem [OPS];
    fmsv_pkg::op_word_t       op_q_reg;
    logic                     op_qv_reg;
    logic [26:0]              busy_acc_reg, best_reg;
    logic [31:0]              incb_reg, phn_reg;
    logic [24:0]              env_lv_reg;
    fmsv_pkg::stage_t         env_st_reg;
    logic                     env_up_reg;
    logic [31:0]              ph_arr_reg [3];
    logic [24:0]              lv_arr_reg [3];
    logic signed [31:0]       rom_q_reg;
    logic                     sign_reg;
    logic signed [32:0]       amp_reg;
    logic signed [SUM_W-1:0]  left_reg, right_reg;
    logic [15:0]              res_l_reg, res_r_reg;
    logic [15:0]              m_left_reg, m_right_reg;

    // multiplier
    logic                          mul_start, mul_busy, mul_done;
    logic [fmsv_pkg::MUL_A_W-1:0]  mul_a;
    logic [fmsv_pkg::MUL_B_W-1:0]  mul_b;
    logic [PW-1:0]                 mul_prod;

    fmsv_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .a       (mul_a),
        .b       (mul_b),
        .busy    (mul_busy),
        .done    (mul_done),
        .prod    (mul_prod)
    );

    // common terms
    logic               s_hs, out_load, last_voice, is_a, wr_en;
    logic [AW-1:0]      op_addr;
    fmsv_pkg::op_word_t op_w, wr_data;
    logic [31:0]        inc_cur, phase_inc;
    logic [24:0]        sus_sel, env_diff, lv_new;
    fmsv_pkg::stage_t   st_new;
    logic [25:0]        atk_sum;
    logic [26:0]        scan_b;
    logic               scan_better;
    logic [1:0]         opk;
    logic               use_prev;
    logic [31:0]        off_sel, amp_x, s_neg, m_val;
    logic [30:0]        s_mag, m1_val;
    logic [16:0]        vol_sel;
    logic signed [32:0] amp_new;
    logic signed [SUM_W-1:0] sum_sel, sum_neg;
    logic [17:0]        mix_r, mix_r_neg;
    logic [15:0]        mix_res;

    assign s_hs       = s_tvalid && s_tready;
    assign out_load   = (state_reg == ST_OUT) && (!m_tvalid_reg || m_tready);
    assign last_voice = (voice_reg == VW'(VOICES - 1));
    assign is_a       = (opj_reg == 2'd0);
    assign op_addr    = AW'((32'(voice_reg) << 1) + 32'(voice_reg) + 32'(opj_reg));
    assign op_w       = op_qv_reg ? op_q_reg : '0;
    assign inc_cur    = voice_inc_reg[voice_reg];
    assign phase_inc  = is_a ? inc_cur : incb_reg;
    assign sus_sel    = is_a ? fmsv_pkg::SUSTAIN_A : fmsv_pkg::SUSTAIN_B;
    assign env_diff   = (op_w.level >= sus_sel) ? op_w.level - sus_sel
                                                : sus_sel - op_w.level;
    assign atk_sum    = 26'(env_lv_reg) + 26'(is_a ? attack_a_reg : attack_b_reg);

    // activity of the voice under scan
    assign scan_b = busy_acc_reg + 27'(op_w.level)
                  + ((op_w.stage != fmsv_pkg::STG_RELEASE) ? 27'(fmsv_pkg::ONE_Q24) : 27'd0);
    assign scan_better = (voice_reg == '0) || (scan_b < best_reg);

    // new envelope level after one tick
    always_comb begin
        lv_new = env_lv_reg;
        st_new = env_st_reg;
        case (env_st_reg)
            fmsv_pkg::STG_RELEASE: lv_new = mul_prod[56:32];
            fmsv_pkg::STG_ATTACK: begin
                if (atk_sum >= fmsv_pkg::ONE_Q24) begin
                    lv_new = 25'(fmsv_pkg::ONE_Q24);
                    st_new = fmsv_pkg::STG_DECAY;
                end else begin
                    lv_new = atk_sum[24:0];
                end
            end
            fmsv_pkg::STG_DECAY:
                lv_new = env_up_reg ? sus_sel + mul_prod[56:32]
                                    : sus_sel - mul_prod[56:32];
            default: lv_new = env_lv_reg;
        endcase
    end

    // operator chain step: which operator, modulation input and offset
    always_comb begin
        if (amp_k_reg inside {3'd0, 3'd3}) begin
            opk = 2'd2;
        end else if (amp_k_reg inside {3'd1, 3'd4}) begin
            opk = 2'd1;
        end else begin
            opk = 2'd0;
        end
        use_prev = (amp_k_reg inside {3'd1, 3'd2, 3'd4, 3'd5});
        if (amp_k_reg == 3'd3) begin
            off_sel = fmsv_pkg::OFFSET_EIGHTH;
        end else if (amp_k_reg inside {3'd4, 3'd5}) begin
            off_sel = fmsv_pkg::OFFSET_QUARTER;
        end else begin
            off_sel = 32'd0;
        end
    end

    assign amp_x   = ph_arr_reg[opk] + (use_prev ? {amp_reg[29:0], 2'b00} : 32'd0) + off_sel;
    assign vol_sel = (opk == 2'd0) ? fmsv_pkg::VOL_A : volume_b_reg;
    assign s_neg   = -rom_q_reg;
    assign s_mag   = rom_q_reg[31] ? s_neg[30:0] : rom_q_reg[30:0];
    assign m1_val  = mul_prod[54:24];
    assign m_val   = mul_prod[47:16];
    assign amp_new = sign_reg ? -$signed({1'b0, m_val}) : $signed({1'b0, m_val});

    // mix: magnitude times scale, truncate, saturate
    assign sum_sel   = side_reg ? right_reg : left_reg;
    assign sum_neg   = -sum_sel;
    assign mix_r     = mul_prod[47:30];
    assign mix_r_neg = -mix_r;
    always_comb begin
        if (!sign_reg) begin
            mix_res = (mix_r > 18'd32767) ? 16'h7FFF : mix_r[15:0];
        end else begin
            mix_res = (mix_r > 18'd32768) ? 16'h8000 : mix_r_neg[15:0];
        end
    end

    // next state, multiplier issue and store writes
    always_comb begin
        state_next = state_reg;
        mul_start  = 1'b0;
        mul_a      = '0;
        mul_b      = '0;
        wr_en      = 1'b0;
        wr_data    = op_w;
        case (state_reg)
            ST_IDLE: begin
                if (s_hs) begin
                    case (s_tuser)
                        fmsv_pkg::MODE_TICK: state_next = ST_INCB;
                        fmsv_pkg::MODE_ON:
                            if (s_tdata[6:0] < fmsv_pkg::NOTE_LIMIT) state_next = ST_SCAN_RD;
                        fmsv_pkg::MODE_OFF:
                            if (s_tdata[6:0] < fmsv_pkg::NOTE_LIMIT) state_next = ST_OFF_CHK;
                        default: state_next = ST_IDLE;
                    endcase
                end
            end
            ST_SCAN_RD: state_next = ST_SCAN;
            ST_SCAN: begin
                if (opj_reg == 2'd2 && last_voice) state_next = ST_ON_RD;
                else state_next = ST_SCAN_RD;
            end
            ST_ON_RD: state_next = ST_ON_WR;
            ST_ON_WR: begin
                wr_en         = 1'b1;
                wr_data.level = '0;
                wr_data.stage = fmsv_pkg::STG_ATTACK;
                state_next    = (opj_reg == 2'd2) ? ST_IDLE : ST_ON_RD;
            end
            ST_OFF_CHK: begin
                if (voice_note_reg[voice_reg] == note_reg) state_next = ST_OFF_RD;
                else if (last_voice) state_next = ST_IDLE;
            end
            ST_OFF_RD: state_next = ST_OFF_WR;
            ST_OFF_WR: begin
                wr_en         = 1'b1;
                wr_data.stage = fmsv_pkg::STG_RELEASE;
                if (opj_reg == 2'd2) state_next = last_voice ? ST_IDLE : ST_OFF_CHK;
                else state_next = ST_OFF_RD;
            end
            ST_INCB: begin
                mul_start  = 1'b1;
                mul_a      = fmsv_pkg::MUL_A_W'(inc_cur);
                mul_b      = fmsv_pkg::MUL_B_W'(tuning_b_reg);
                state_next = ST_MWAIT;
            end
            ST_RD: state_next = ST_ENV;
            ST_ENV: begin
                if (op_w.stage == fmsv_pkg::STG_RELEASE) begin
                    mul_start  = 1'b1;
                    mul_a      = fmsv_pkg::MUL_A_W'(op_w.level);
                    mul_b      = is_a ? release_a_reg : release_b_reg;
                    state_next = ST_MWAIT;
                end else if (op_w.stage == fmsv_pkg::STG_DECAY) begin
                    mul_start  = 1'b1;
                    mul_a      = fmsv_pkg::MUL_A_W'(env_diff);
                    mul_b      = is_a ? decay_a_reg : decay_b_reg;
                    state_next = ST_MWAIT;
                end else begin
                    state_next = ST_ENV_WR;
                end
            end
            ST_ENV_WR: begin
                wr_en         = 1'b1;
                wr_data.phase = phn_reg;
                wr_data.level = lv_new;
                wr_data.stage = st_new;
                state_next    = (opj_reg == 2'd2) ? ST_AMP_IDX : ST_RD;
            end
            ST_AMP_IDX: begin
                mul_start  = 1'b1;
                mul_a      = fmsv_pkg::MUL_A_W'(SINE_ENTRIES);
                mul_b      = amp_x;
                state_next = ST_MWAIT;
            end
            ST_AMP_ROM: begin
                mul_start  = 1'b1;
                mul_a      = fmsv_pkg::MUL_A_W'(s_mag);
                mul_b      = fmsv_pkg::MUL_B_W'(lv_arr_reg[opk]);
                state_next = ST_MWAIT;
            end
            ST_AMP_M2: begin
                mul_start  = 1'b1;
                mul_a      = fmsv_pkg::MUL_A_W'(m1_val);
                mul_b      = fmsv_pkg::MUL_B_W'(vol_sel);
                state_next = ST_MWAIT;
            end
            ST_AMP_END: begin
                if (amp_k_reg == 3'd5) state_next = last_voice ? ST_MIX : ST_INCB;
                else state_next = ST_AMP_IDX;
            end
            ST_MIX: begin
                mul_start  = 1'b1;
                mul_a      = sum_sel[SUM_W-1] ? sum_neg[fmsv_pkg::MUL_A_W-1:0]
                                              : sum_sel[fmsv_pkg::MUL_A_W-1:0];
                mul_b      = fmsv_pkg::MIX_SCALE;
                state_next = ST_MWAIT;
            end
            ST_MIX_END: state_next = side_reg ? ST_OUT : ST_MIX;
            ST_OUT: if (out_load) state_next = ST_IDLE;
            ST_MWAIT: if (mul_done) state_next = ret_reg;
            default: state_next = ST_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            ret_reg       <= ST_IDLE;
            m_tvalid_reg  <= 1'b0;
            op_vld_reg    <= '0;
            voice_reg     <= '0;
            opj_reg       <= 2'd0;
            amp_k_reg     <= 3'd0;
            side_reg      <= 1'b0;
            attack_a_reg  <= fmsv_pkg::RST_ATTACK_A;
            attack_b_reg  <= fmsv_pkg::RST_ATTACK_B;
            decay_a_reg   <= fmsv_pkg::RST_DECAY_A;
            decay_b_reg   <= fmsv_pkg::RST_DECAY_B;
            release_a_reg <= fmsv_pkg::RST_RELEASE_A;
            release_b_reg <= fmsv_pkg::RST_RELEASE_B;
            tuning_b_reg  <= fmsv_pkg::RST_TUNING_B;
            volume_b_reg  <= fmsv_pkg::RST_VOLUME_B;
            for (int v = 0; v < VOICES; v++) begin
                voice_note_reg[v] <= 7'd0;
                voice_inc_reg[v]  <= 32'd0;
            end
        end else begin
            state_reg <= state_next;

            // configuration transaction
            if (cfg_valid) begin
                case (cfg_index)
                    fmsv_pkg::CFG_ATTACK_A:  attack_a_reg  <= cfg_data[24:0];
                    fmsv_pkg::CFG_ATTACK_B:  attack_b_reg  <= cfg_data[24:0];
                    fmsv_pkg::CFG_DECAY_A:   decay_a_reg   <= cfg_data;
                    fmsv_pkg::CFG_DECAY_B:   decay_b_reg   <= cfg_data;
                    fmsv_pkg::CFG_RELEASE_A: release_a_reg <= cfg_data;
                    fmsv_pkg::CFG_RELEASE_B: release_b_reg <= cfg_data;
                    fmsv_pkg::CFG_TUNING_B:  tuning_b_reg  <= cfg_data[19:0];
                    fmsv_pkg::CFG_VOLUME_B:  volume_b_reg  <= cfg_data[16:0];
                    default: ;
                endcase
            end

            // result register
            if (out_load) m_tvalid_reg <= 1'b1;
            else if (m_tready) m_tvalid_reg <= 1'b0;

            if (wr_en) op_vld_reg[op_addr] <= 1'b1;

            // return point after a multiply
            case (state_reg)
                ST_INCB:    ret_reg <= ST_RD;
                ST_ENV:     ret_reg <= ST_ENV_WR;
                ST_AMP_IDX: ret_reg <= ST_AMP_ROM;
                ST_AMP_ROM: ret_reg <= ST_AMP_M2;
                ST_AMP_M2:  ret_reg <= ST_AMP_END;
                ST_MIX:     ret_reg <= ST_MIX_END;
                default:    ret_reg <= ret_reg;
            endcase

            // loop counters
            case (state_reg)
                ST_IDLE: begin
                    voice_reg <= '0;
                    opj_reg   <= 2'd0;
                end
                ST_SCAN: begin
                    if (opj_reg == 2'd2) begin
                        opj_reg <= 2'd0;
                        if (last_voice) voice_reg <= scan_better ? voice_reg : best_v_reg;
                        else voice_reg <= voice_reg + 1'b1;
                    end else begin
                        opj_reg <= opj_reg + 1'b1;
                    end
                end
                ST_ON_WR: begin
                    voice_note_reg[voice_reg] <= note_reg;
                    voice_inc_reg[voice_reg]  <= note_increment(note_reg);
                    opj_reg <= opj_reg + 1'b1;
                end
                ST_OFF_CHK: begin
                    opj_reg <= 2'd0;
                    if (voice_note_reg[voice_reg] != note_reg && !last_voice)
                        voice_reg <= voice_reg + 1'b1;
                end
                ST_OFF_WR: begin
                    opj_reg <= opj_reg + 1'b1;
                    if (opj_reg == 2'd2 && !last_voice) voice_reg <= voice_reg + 1'b1;
                end
                ST_INCB: opj_reg <= 2'd0;
                ST_ENV_WR: begin
                    opj_reg   <= opj_reg + 1'b1;
                    amp_k_reg <= 3'd0;
                end
                ST_AMP_END: begin
                    amp_k_reg <= amp_k_reg + 1'b1;
                    side_reg  <= 1'b0;
                    if (amp_k_reg == 3'd5 && !last_voice) voice_reg <= voice_reg + 1'b1;
                end
                ST_MIX_END: side_reg <= 1'b1;
                default: ;
            endcase
        end
    end

    // operator store, registered read with write bypass
    always_ff @(posedge aclk) begin
        if (wr_en) op_mem[op_addr] <= wr_data;
        op_q_reg  <= wr_en ? wr_data : op_mem[op_addr];
        op_qv_reg <= wr_en || op_vld_reg[op_addr];
    end

    // sine table, registered read from the index product
    always_ff @(posedge aclk) begin
        rom_q_reg <= SINE_ROM[mul_prod[32+IW-1:32]];
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                note_reg     <= s_tdata[6:0];
                busy_acc_reg <= '0;
                left_reg     <= '0;
                right_reg    <= '0;
            end
            ST_SCAN: begin
                if (opj_reg == 2'd2) begin
                    busy_acc_reg <= '0;
                    if (scan_better) begin
                        best_reg   <= scan_b;
                        best_v_reg <= voice_reg;
                    end
                end else begin
                    busy_acc_reg <= scan_b;
                end
            end
            ST_RD: if (is_a) incb_reg <= mul_prod[47:16];
            ST_ENV: begin
                phn_reg    <= op_w.phase + phase_inc;
                env_lv_reg <= op_w.level;
                env_st_reg <= op_w.stage;
                env_up_reg <= (op_w.level >= sus_sel);
            end
            ST_ENV_WR: begin
                ph_arr_reg[opj_reg] <= phn_reg;
                lv_arr_reg[opj_reg] <= lv_new;
            end
            ST_AMP_ROM: sign_reg <= rom_q_reg[31];
            ST_AMP_END: begin
                amp_reg <= amp_new;
                if (amp_k_reg == 3'd2) left_reg  <= left_reg + SUM_W'(amp_new);
                if (amp_k_reg == 3'd5) right_reg <= right_reg + SUM_W'(amp_new);
            end
            ST_MIX: sign_reg <= sum_sel[SUM_W-1];
            ST_MIX_END: begin
                if (side_reg) res_r_reg <= mix_res;
                else res_l_reg <= mix_res;
            end
            ST_OUT: begin
                if (out_load) begin
                    m_left_reg  <= res_l_reg;
                    m_right_reg <= res_r_reg;
                end
            end
            default: ;
        endcase
    end

    assign s_tready  = (state_reg == ST_IDLE);
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = {m_right_reg, m_left_reg};
    assign cfg_ready = 1'b1;

    // checks
    `FMSV_ASSERT_IMPLY(a_idle_mul_quiet, state_reg == ST_IDLE, !mul_busy)
    `FMSV_ASSERT_IMPLY(a_wait_has_mul, (state_reg == ST_MWAIT) && !mul_done, mul_busy)
    `FMSV_ASSERT_IMPLY(a_wr_in_range, wr_en, 32'(op_addr) < OPS)
    `FMSV_ASSERT_NEXT(a_out_loads, out_load, m_tvalid && (state_reg == ST_IDLE))

endmodule
